// ----- rtl/lpi_pkg.sv -----
// shared types, constants and saturation helper for the line/plane intersection block
`timescale 1ns / 1ps
`default_nettype none
package lpi_pkg;

    localparam int CW     = 32;
    localparam int NW     = 32;
    localparam int FRAC_N = 30;
    localparam int FRAC_C = 16;
    localparam int SW     = 67;
    localparam int MW     = 66;
    localparam int QW     = 33;
    localparam int OVF_SH = QW - FRAC_C;
    localparam int PW     = CW + CW + 1;
    localparam int XW     = 72;
    localparam int CFG_IW = 8;

    localparam logic [CFG_IW-1:0] REG_NX  = CFG_IW'(0);
    localparam logic [CFG_IW-1:0] REG_NY  = CFG_IW'(1);
    localparam logic [CFG_IW-1:0] REG_NZ  = CFG_IW'(2);
    localparam logic [CFG_IW-1:0] REG_OFF = CFG_IW'(3);

    localparam logic [CW-1:0] CMAX = {1'b0, {(CW-1){1'b1}}};
    localparam logic [CW-1:0] CMIN = {1'b1, {(CW-1){1'b0}}};
    localparam logic [NW-1:0] NZ_RESET = NW'(1) << FRAC_N;

    typedef logic signed [CW-1:0] t_coord;

    typedef struct packed {
        logic [2:0][CW-1:0] f;
        logic [2:0][CW-1:0] t;
    } t_seg;

    typedef struct packed {
        logic [2:0][CW-1:0] f;
        logic [2:0][CW:0]   d;
    } t_geom;

    typedef struct packed {
        logic signed [NW-1:0] nx;
        logic signed [NW-1:0] ny;
        logic signed [NW-1:0] nz;
        logic signed [NW-1:0] off;
    } t_cfg;

    typedef struct packed {
        t_geom         g;
        logic [CW-1:0] sd;
        logic          par;
        logic          hit;
        logic          qneg;
    } t_item;

    typedef struct packed {
        t_item         it;
        logic [MW-1:0] an;
        logic [MW-1:0] ad;
    } t_frac;

    typedef struct packed {
        t_item         it;
        logic          ovf;
        logic [QW-1:0] q;
    } t_quot;

    function automatic logic [CW-1:0] sat_coord(input logic signed [XW-1:0] v);
        logic signed [XW-1:0] mx;
        logic signed [XW-1:0] mn;
        mx = {{(XW-CW+1){1'b0}}, {(CW-1){1'b1}}};
        mn = ~mx;
        if (v > mx) begin
            return mx[CW-1:0];
        end else if (v < mn) begin
            return mn[CW-1:0];
        end
        return v[CW-1:0];
    endfunction

endpackage
`default_nettype wire

// ----- rtl/lpi_dot.sv -----
// front pipeline: direction, dot products with the normal, sums and sign handling
`timescale 1ns / 1ps
`default_nettype none
module lpi_dot (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_ready,
    input  wire lpi_pkg::t_seg i_seg,
    input  wire lpi_pkg::t_cfg i_cfg,
    output logic               o_valid,
    input  wire logic          i_ready,
    output lpi_pkg::t_frac     o_frac
);

    localparam int NS = 5;

    logic [NS-1:0] r_v;
    logic [NS:0]   w_rdy;

    lpi_pkg::t_geom r_g1, r_g2, r_g3, r_g4;
    lpi_pkg::t_geom n_g1;
    logic signed [lpi_pkg::NW+lpi_pkg::CW-1:0] r_pn [3];
    logic signed [lpi_pkg::NW+lpi_pkg::CW-1:0] n_pn [3];
    logic signed [lpi_pkg::PW-1:0]             r_pd [3];
    logic signed [lpi_pkg::PW-1:0]             n_pd [3];
    logic signed [lpi_pkg::SW-1:0] r_na, r_nb, r_da, r_db, r_num, r_den;
    logic signed [lpi_pkg::SW-1:0] n_na, n_nb, n_da, n_db;
    logic signed [lpi_pkg::NW-1:0] w_n [3];
    logic signed [lpi_pkg::NW+lpi_pkg::FRAC_N-1:0] w_off_sh;
    lpi_pkg::t_frac r_frac, n_frac;
    logic w_nneg, w_dneg, w_par;

    assign w_n[0]   = i_cfg.nx;
    assign w_n[1]   = i_cfg.ny;
    assign w_n[2]   = i_cfg.nz;
    assign w_off_sh = $signed({i_cfg.off, {lpi_pkg::FRAC_N{1'b0}}});

    always_comb begin
        w_rdy[NS] = i_ready;
        for (int k = NS - 1; k >= 0; k--) begin
            w_rdy[k] = ~r_v[k] | w_rdy[k+1];
        end
    end

    assign o_ready = w_rdy[0];
    assign o_valid = r_v[NS-1];
    assign o_frac  = r_frac;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_g1.f[i] = i_seg.f[i];
            n_g1.d[i] = {i_seg.t[i][lpi_pkg::CW-1], i_seg.t[i]}
                      - {i_seg.f[i][lpi_pkg::CW-1], i_seg.f[i]};
            n_pn[i]   = (lpi_pkg::NW+lpi_pkg::CW)'(w_n[i])
                      * (lpi_pkg::NW+lpi_pkg::CW)'($signed(r_g1.f[i]));
            n_pd[i]   = lpi_pkg::PW'(w_n[i]) * lpi_pkg::PW'($signed(r_g1.d[i]));
        end
        n_na = lpi_pkg::SW'(w_off_sh) + lpi_pkg::SW'(r_pn[0]);
        n_nb = lpi_pkg::SW'(r_pn[1]) + lpi_pkg::SW'(r_pn[2]);
        n_da = lpi_pkg::SW'(r_pd[0]) + lpi_pkg::SW'(r_pd[1]);
        n_db = lpi_pkg::SW'(r_pd[2]);
    end

    always_comb begin
        w_nneg          = r_num[lpi_pkg::SW-1];
        w_dneg          = r_den[lpi_pkg::SW-1];
        w_par           = (r_den == '0);
        n_frac.it.g     = r_g4;
        n_frac.it.sd    = lpi_pkg::sat_coord(lpi_pkg::XW'(r_num >>> lpi_pkg::FRAC_N));
        n_frac.it.par   = w_par;
        n_frac.it.hit   = ~w_par & ((r_num == '0) | (w_nneg ^ w_dneg));
        n_frac.it.qneg  = w_nneg ^ w_dneg;
        n_frac.an       = lpi_pkg::MW'(w_nneg ? -r_num : r_num);
        n_frac.ad       = lpi_pkg::MW'(w_dneg ? -r_den : r_den);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (w_rdy[0]) begin
                r_v[0] <= i_valid;
            end
            for (int k = 1; k < NS; k++) begin
                if (w_rdy[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy[0]) begin
            r_g1 <= n_g1;
        end
        if (w_rdy[1]) begin
            r_g2 <= r_g1;
            r_pn <= n_pn;
            r_pd <= n_pd;
        end
        if (w_rdy[2]) begin
            r_g3 <= r_g2;
            r_na <= n_na;
            r_nb <= n_nb;
            r_da <= n_da;
            r_db <= n_db;
        end
        if (w_rdy[3]) begin
            r_g4  <= r_g3;
            r_num <= r_na + r_nb;
            r_den <= r_da + r_db;
        end
        if (w_rdy[4]) begin
            r_frac <= n_frac;
        end
    end

endmodule
`default_nettype wire

// ----- rtl/lpi_div.sv -----
// pipelined restoring divider, one quotient bit per stage, with overflow detect
`timescale 1ns / 1ps
`default_nettype none
module lpi_div (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_valid,
    output logic                o_ready,
    input  wire lpi_pkg::t_frac i_frac,
    output logic                o_valid,
    input  wire logic           i_ready,
    output lpi_pkg::t_quot      o_quot
);

    localparam int NS = lpi_pkg::QW + 1;

    typedef struct packed {
        lpi_pkg::t_item         it;
        logic                   ovf;
        logic [lpi_pkg::MW-1:0] ad;
        logic [lpi_pkg::MW-1:0] rem;
        logic [lpi_pkg::QW-1:0] q;
        logic [lpi_pkg::QW-1:0] lo;
    } t_dstage;

    function automatic t_dstage div_step(input t_dstage s);
        t_dstage                r;
        logic [lpi_pkg::MW:0]   r2;
        logic [lpi_pkg::MW:0]   diff;
        logic                   ge;
        r    = s;
        r2   = {s.rem, s.lo[lpi_pkg::QW-1]};
        diff = r2 - {1'b0, s.ad};
        ge   = (r2 >= {1'b0, s.ad});
        r.rem = ge ? diff[lpi_pkg::MW-1:0] : r2[lpi_pkg::MW-1:0];
        r.q   = {s.q[lpi_pkg::QW-2:0], ge};
        r.lo  = {s.lo[lpi_pkg::QW-2:0], 1'b0};
        return r;
    endfunction

    logic [NS-1:0] r_v;
    logic [NS:0]   w_rdy;
    t_dstage       r_st [NS];
    t_dstage       n_st0;

    always_comb begin
        w_rdy[NS] = i_ready;
        for (int k = NS - 1; k >= 0; k--) begin
            w_rdy[k] = ~r_v[k] | w_rdy[k+1];
        end
    end

    always_comb begin
        n_st0.it  = i_frac.it;
        n_st0.ad  = i_frac.ad;
        n_st0.ovf = ({{lpi_pkg::OVF_SH{1'b0}}, i_frac.an}
                  >= {i_frac.ad, {lpi_pkg::OVF_SH{1'b0}}});
        n_st0.rem = i_frac.an >> lpi_pkg::OVF_SH;
        n_st0.q   = '0;
        n_st0.lo  = {i_frac.an[lpi_pkg::OVF_SH-1:0], {lpi_pkg::FRAC_C{1'b0}}};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (w_rdy[0]) begin
                r_v[0] <= i_valid;
            end
            for (int k = 1; k < NS; k++) begin
                if (w_rdy[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy[0]) begin
            r_st[0] <= n_st0;
        end
    end

    for (genvar k = 1; k < NS; k++) begin : g_stage
        always_ff @(posedge i_clk) begin
            if (w_rdy[k]) begin
                r_st[k] <= div_step(r_st[k-1]);
            end
        end
    end

    assign o_ready     = w_rdy[0];
    assign o_valid     = r_v[NS-1];
    assign o_quot.it   = r_st[NS-1].it;
    assign o_quot.ovf  = r_st[NS-1].ovf;
    assign o_quot.q    = r_st[NS-1].q;

endmodule
`default_nettype wire

// ----- rtl/lpi_proj.sv -----
// back pipeline: quotient saturation, scaling of the direction and final point
`timescale 1ns / 1ps
`default_nettype none
module lpi_proj (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_valid,
    output logic                o_ready,
    input  wire lpi_pkg::t_quot i_quot,
    output logic                o_valid,
    input  wire logic           i_ready,
    output logic [lpi_pkg::CW-1:0] o_side_distance,
    output logic                o_parallel,
    output logic                o_hit,
    output logic [lpi_pkg::CW-1:0] o_hit_x,
    output logic [lpi_pkg::CW-1:0] o_hit_y,
    output logic [lpi_pkg::CW-1:0] o_hit_z
);

    localparam int NS = 4;
    localparam logic [lpi_pkg::QW-1:0] PLIM = {2'b00, {(lpi_pkg::CW-1){1'b1}}};
    localparam logic [lpi_pkg::QW-1:0] NLIM = {2'b01, {(lpi_pkg::CW-1){1'b0}}};

    logic [NS-1:0] r_v;
    logic [NS:0]   w_rdy;

    lpi_pkg::t_item r_it1, r_it2, r_it3;
    logic [lpi_pkg::CW-1:0] r_y, n_y;
    logic signed [lpi_pkg::PW-1:0] r_p [3];
    logic signed [lpi_pkg::PW-1:0] n_p [3];
    logic [lpi_pkg::CW-1:0] r_ps [3];
    logic [lpi_pkg::CW-1:0] n_ps [3];
    logic [lpi_pkg::CW-1:0] r_h [3];
    logic [lpi_pkg::CW-1:0] n_h [3];
    logic [lpi_pkg::CW-1:0] r_sd;
    logic r_par, r_hit;
    logic signed [lpi_pkg::CW:0] w_diff [3];

    always_comb begin
        w_rdy[NS] = i_ready;
        for (int k = NS - 1; k >= 0; k--) begin
            w_rdy[k] = ~r_v[k] | w_rdy[k+1];
        end
    end

    always_comb begin
        if (i_quot.it.qneg) begin
            n_y = (i_quot.ovf | (i_quot.q > NLIM)) ? lpi_pkg::CMIN
                                                    : lpi_pkg::CW'(-i_quot.q);
        end else begin
            n_y = (i_quot.ovf | (i_quot.q > PLIM)) ? lpi_pkg::CMAX
                                                    : i_quot.q[lpi_pkg::CW-1:0];
        end
        for (int i = 0; i < 3; i++) begin
            n_p[i]    = lpi_pkg::PW'($signed(r_y)) * lpi_pkg::PW'($signed(r_it1.g.d[i]));
            n_ps[i]   = lpi_pkg::sat_coord(lpi_pkg::XW'(r_p[i] >>> lpi_pkg::FRAC_C));
            w_diff[i] = $signed({r_it3.g.f[i][lpi_pkg::CW-1], r_it3.g.f[i]})
                      - $signed({r_ps[i][lpi_pkg::CW-1], r_ps[i]});
            n_h[i]    = r_it3.par ? '0 : lpi_pkg::sat_coord(lpi_pkg::XW'(w_diff[i]));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (w_rdy[0]) begin
                r_v[0] <= i_valid;
            end
            for (int k = 1; k < NS; k++) begin
                if (w_rdy[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy[0]) begin
            r_it1 <= i_quot.it;
            r_y   <= n_y;
        end
        if (w_rdy[1]) begin
            r_it2 <= r_it1;
            r_p   <= n_p;
        end
        if (w_rdy[2]) begin
            r_it3 <= r_it2;
            r_ps  <= n_ps;
        end
        if (w_rdy[3]) begin
            r_sd  <= r_it3.sd;
            r_par <= r_it3.par;
            r_hit <= r_it3.hit;
            r_h   <= n_h;
        end
    end

    assign o_ready         = w_rdy[0];
    assign o_valid         = r_v[NS-1];
    assign o_side_distance = r_sd;
    assign o_parallel      = r_par;
    assign o_hit           = r_hit;
    assign o_hit_x         = r_h[0];
    assign o_hit_y         = r_h[1];
    assign o_hit_z         = r_h[2];

endmodule
`default_nettype wire

// ----- rtl/line_plane_intersection.sv -----
// top level of the line/plane intersection block with plane registers
`timescale 1ns / 1ps
`default_nettype none
// Takes one segment beat per clock while o_in_ready is high and returns one result beat per
// segment, in order, after it has passed the 5-stage dot-product front end, the 34-stage
// restoring divider (one quotient bit per stage) and the 4-stage scaling back end.
// Each stage holds its beat until the next stage frees, so gaps anywhere in the pipe
// close up under a stall.
// Plane registers are written through the config channel, which is always ready;
// write them only while no segment is in flight.
module line_plane_intersection (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_in_valid,
    output logic                             o_in_ready,
    input  wire logic [lpi_pkg::CW-1:0]      i_from_x,
    input  wire logic [lpi_pkg::CW-1:0]      i_from_y,
    input  wire logic [lpi_pkg::CW-1:0]      i_from_z,
    input  wire logic [lpi_pkg::CW-1:0]      i_to_x,
    input  wire logic [lpi_pkg::CW-1:0]      i_to_y,
    input  wire logic [lpi_pkg::CW-1:0]      i_to_z,
    output logic                             o_out_valid,
    input  wire logic                        i_out_ready,
    output logic [lpi_pkg::CW-1:0]           o_side_distance,
    output logic                             o_parallel,
    output logic                             o_hit,
    output logic [lpi_pkg::CW-1:0]           o_hit_x,
    output logic [lpi_pkg::CW-1:0]           o_hit_y,
    output logic [lpi_pkg::CW-1:0]           o_hit_z,
    input  wire logic                        i_cfg_valid,
    output logic                             o_cfg_ready,
    input  wire logic [lpi_pkg::CFG_IW-1:0]  i_cfg_index,
    input  wire logic [lpi_pkg::NW-1:0]      i_cfg_data
);

    lpi_pkg::t_cfg  r_cfg;
    lpi_pkg::t_seg  w_seg;
    lpi_pkg::t_frac w_frac;
    lpi_pkg::t_quot w_quot;
    logic w_frac_valid, w_frac_ready, w_quot_valid, w_quot_ready;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.nx  <= '0;
            r_cfg.ny  <= '0;
            r_cfg.nz  <= lpi_pkg::NZ_RESET;
            r_cfg.off <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                lpi_pkg::REG_NX:  r_cfg.nx  <= i_cfg_data;
                lpi_pkg::REG_NY:  r_cfg.ny  <= i_cfg_data;
                lpi_pkg::REG_NZ:  r_cfg.nz  <= i_cfg_data;
                lpi_pkg::REG_OFF: r_cfg.off <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign w_seg.f[0] = i_from_x;
    assign w_seg.f[1] = i_from_y;
    assign w_seg.f[2] = i_from_z;
    assign w_seg.t[0] = i_to_x;
    assign w_seg.t[1] = i_to_y;
    assign w_seg.t[2] = i_to_z;

    lpi_dot u_dot (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_ready (o_in_ready),
        .i_seg   (w_seg),
        .i_cfg   (r_cfg),
        .o_valid (w_frac_valid),
        .i_ready (w_frac_ready),
        .o_frac  (w_frac)
    );

    lpi_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_frac_valid),
        .o_ready (w_frac_ready),
        .i_frac  (w_frac),
        .o_valid (w_quot_valid),
        .i_ready (w_quot_ready),
        .o_quot  (w_quot)
    );

    lpi_proj u_proj (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (w_quot_valid),
        .o_ready         (w_quot_ready),
        .i_quot          (w_quot),
        .o_valid         (o_out_valid),
        .i_ready         (i_out_ready),
        .o_side_distance (o_side_distance),
        .o_parallel      (o_parallel),
        .o_hit           (o_hit),
        .o_hit_x         (o_hit_x),
        .o_hit_y         (o_hit_y),
        .o_hit_z         (o_hit_z)
    );

endmodule
`default_nettype wire

// ----- rtl/lpi_chk.sv -----
// port-level checker for the line/plane intersection block, bound to the top level
`timescale 1ns / 1ps
`default_nettype none
module lpi_chk (
    input wire logic                   i_clk,
    input wire logic                   i_rst_n,
    input wire logic                   o_out_valid,
    input wire logic                   i_out_ready,
    input wire logic [lpi_pkg::CW-1:0] o_side_distance,
    input wire logic                   o_parallel,
    input wire logic                   o_hit,
    input wire logic [lpi_pkg::CW-1:0] o_hit_x,
    input wire logic [lpi_pkg::CW-1:0] o_hit_y,
    input wire logic [lpi_pkg::CW-1:0] o_hit_z
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result beat dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> $stable(o_side_distance) && $stable(o_hit_x)
            && $stable(o_hit_y) && $stable(o_hit_z) && $stable(o_hit)
            && $stable(o_parallel))
        else $error("result beat changed while stalled");

    a_par_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_parallel |-> !o_hit && o_hit_x == '0 && o_hit_y == '0
            && o_hit_z == '0)
        else $error("parallel result with a hit or nonzero point");

    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result beat right after reset");

endmodule

bind line_plane_intersection lpi_chk u_lpi_chk (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_out_valid     (o_out_valid),
    .i_out_ready     (i_out_ready),
    .o_side_distance (o_side_distance),
    .o_parallel      (o_parallel),
    .o_hit           (o_hit),
    .o_hit_x         (o_hit_x),
    .o_hit_y         (o_hit_y),
    .o_hit_z         (o_hit_z)
);
`default_nettype wire
